// ===== hw/rtl/drm_pkg.sv =====
// ----------------------------------------------------------------------------
// drm_pkg
// Shared widths, payload structs, register codes and knee helper for the
// diode ring modulator.
// ----------------------------------------------------------------------------
package drm_pkg;

  // sample format
  localparam int SAMPLE_BITS = 24;

  // diode stage works in units of 2^-24
  localparam int DIODE_FRAC = 24;
  localparam int DIODE_W    = 27;
  localparam int MAG_W      = DIODE_W - 1;
  localparam int SUM_W      = SAMPLE_BITS + 3;

  // input rescale to the diode grid
  localparam int IN_SHIFT   = DIODE_FRAC - SAMPLE_BITS;
  localparam int IN_LSH     = (IN_SHIFT > 0) ? IN_SHIFT : 0;
  localparam int IN_RSH     = (IN_SHIFT < 0) ? -IN_SHIFT : 0;
  localparam int IN_WIDE_W  = SUM_W + IN_LSH;

  // configuration port
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int BIAS_SHIFT = 8;
  localparam int KN_W       = CFG_W + 1;
  localparam int KNEE_GAP_Q16 = 1311;
  localparam logic [CFG_W-1:0] FORWARD_BIAS_RESET = 16'd19661;
  localparam logic [CFG_W-1:0] LINEAR_KNEE_RESET  = 16'd45875;

  // quadratic segment and its divider
  localparam int D_W        = CFG_W + BIAS_SHIFT;
  localparam int VL_W       = D_W + 1;
  localparam int HG_W       = D_W - 1;
  localparam int SQ_SHIFT   = BIAS_SHIFT + 1;
  localparam int NUM_W      = 2 * D_W - SQ_SHIFT;
  localparam int REM_W      = CFG_W;
  localparam int QUO_W      = NUM_W - REM_W;
  localparam int DIV_STAGES = QUO_W;

  // soft clip
  localparam int X_W        = MAG_W + 2;
  localparam int AX_W       = X_W - 1;
  localparam int S_W        = 2 * AX_W - DIODE_FRAC;
  localparam int C_W        = S_W + AX_W - DIODE_FRAC;
  localparam int Z_W        = C_W + 2;
  localparam int Z_FRAC     = DIODE_FRAC + 1;
  localparam int OUT_SHIFT  = SAMPLE_BITS - 1 - Z_FRAC;
  localparam int OUT_LSH    = (OUT_SHIFT > 0) ? OUT_SHIFT : 0;
  localparam int OUT_RSH    = (OUT_SHIFT < 0) ? -OUT_SHIFT : 0;
  localparam int Y_W        = Z_W + OUT_LSH;

  // pipeline shape
  localparam int LANE_STAGES = DIV_STAGES + 4;
  localparam int CLIP_STAGES = 6;
  localparam int NUM_STAGES  = 1 + LANE_STAGES + CLIP_STAGES;

  // diode lanes
  localparam int NUM_LANES    = 4;
  localparam int LANE_A_LEFT  = 0;
  localparam int LANE_B_LEFT  = 1;
  localparam int LANE_A_RIGHT = 2;
  localparam int LANE_B_RIGHT = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FORWARD_BIAS = 1'b0,
    CFG_LINEAR_KNEE  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [D_W-1:0]   vb;
    logic [VL_W-1:0]  vl;
    logic [REM_W-1:0] gap;
    logic [HG_W-1:0]  half_gap;
  } drm_knee_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    logic signed [SAMPLE_BITS-1:0] carrier_left;
    logic signed [SAMPLE_BITS-1:0] carrier_right;
  } drm_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;
  } drm_out_t;

  // knee forced at least a small gap above the bias, all on the 2^-24 grid
  function automatic drm_knee_t knee_calc(input logic [CFG_W-1:0] bias,
                                          input logic [CFG_W-1:0] knee);
    logic [KN_W-1:0] low_knee;
    logic [KN_W-1:0] eff_knee;
    drm_knee_t       r;
    low_knee   = KN_W'(bias) + KN_W'(KNEE_GAP_Q16);
    eff_knee   = (KN_W'(knee) < low_knee) ? low_knee : KN_W'(knee);
    r.vb       = D_W'(bias) << BIAS_SHIFT;
    r.vl       = VL_W'(eff_knee) << BIAS_SHIFT;
    r.gap      = REM_W'(eff_knee - KN_W'(bias));
    r.half_gap = HG_W'(r.gap) << (BIAS_SHIFT - 1);
    return r;
  endfunction

endpackage

// ===== hw/rtl/diode_ring_modulator.sv =====
// ----------------------------------------------------------------------------
// diode_ring_modulator
// pipeline: 34 register stages from the input register to the output register
// throughput: one item per cycle, sustained with the output taking every cycle
// depth is set by the 23 one-bit steps of the restoring divider in each diode lane
// reset: valid bits cleared, bias and knee back to 19661 and 45875, no sweep
// ----------------------------------------------------------------------------
module diode_ring_modulator import drm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,

  // configuration writes
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,

  // input items
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  drm_in_t              in_data_i,

  // result items
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output drm_out_t             out_data_o
);

  // configuration registers and the derived knee set
  logic [CFG_W-1:0] forward_bias_q;
  logic [CFG_W-1:0] linear_knee_q;
  drm_knee_t        knee_q;

  // pipeline control: one valid bit per stage, stage_en moves a stage forward
  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES-1:0] stage_en;

  // stage 0: diode voltages A and B for both channels
  logic signed [DIODE_W-1:0] volt_d [NUM_LANES];
  logic signed [DIODE_W-1:0] volt_q [NUM_LANES];

  logic [MAG_W-1:0]              curr [NUM_LANES];
  logic signed [SAMPLE_BITS-1:0] clip_y;

  // config regs; the knee set is registered from them in the cycle after a write,
  // before an item taken with that write reaches a diode lane compare
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      forward_bias_q <= FORWARD_BIAS_RESET;
      linear_knee_q  <= LINEAR_KNEE_RESET;
      knee_q         <= knee_calc(FORWARD_BIAS_RESET, LINEAR_KNEE_RESET);
    end else begin
      knee_q <= knee_calc(forward_bias_q, linear_knee_q);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FORWARD_BIAS: forward_bias_q <= cfg_wdata_i;
          CFG_LINEAR_KNEE:  linear_knee_q  <= cfg_wdata_i;
          default:          ;
        endcase
      end
    end
  end

  // a stage may load when some stage from it to the output is empty, or the
  // output is being taken; bubbles close up even while the output is stalled
  always_comb begin
    logic [NUM_STAGES-1:0] tail_mask;
    for (int s = 0; s < NUM_STAGES; s++) begin
      tail_mask   = ~((NUM_STAGES'(1) << s) - NUM_STAGES'(1));
      stage_en[s] = !out_stall_i || ((valid_q & tail_mask) != tail_mask);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (stage_en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int s = 1; s < NUM_STAGES; s++) begin
        if (stage_en[s]) begin
          valid_q[s] <= valid_q[s-1];
        end
      end
    end
  end

  assign in_stall_o = !stage_en[0];

  // A = in/2 + 2*carrier and B = 2*carrier - in/2, formed exactly as
  // in + 4*carrier at the sample scale, then moved onto the 2^-24 grid
  always_comb begin
    logic signed [SUM_W-1:0]     sum   [NUM_LANES];
    logic signed [SUM_W-1:0]     car4_l, car4_r;
    logic signed [IN_WIDE_W-1:0] wide;
    logic signed [IN_WIDE_W-1:0] shifted;
    car4_l = SUM_W'(in_data_i.carrier_left) <<< 2;
    car4_r = SUM_W'(in_data_i.carrier_right) <<< 2;
    sum[LANE_A_LEFT]  = car4_l + SUM_W'(in_data_i.left_in);
    sum[LANE_B_LEFT]  = car4_l - SUM_W'(in_data_i.left_in);
    sum[LANE_A_RIGHT] = car4_r + SUM_W'(in_data_i.right_in);
    sum[LANE_B_RIGHT] = car4_r - SUM_W'(in_data_i.right_in);
    for (int l = 0; l < NUM_LANES; l++) begin
      wide      = IN_WIDE_W'(sum[l]);
      shifted   = (wide <<< IN_LSH) >>> IN_RSH;
      volt_d[l] = shifted[DIODE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[0]) begin
      volt_q <= volt_d;
    end
  end

  // four diode lanes: A and B of each channel, each pair of diodes on |v|
  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    drm_diode_lane u_lane (
      .clk_i      (clk_i),
      .stage_en_i (stage_en[1 +: LANE_STAGES]),
      .knee_i     (knee_q),
      .volt_i     (volt_q[l]),
      .curr_o     (curr[l])
    );
  end

  // channel sum, soft clip and saturation; the last stage is the output register
  drm_soft_clip u_soft_clip (
    .clk_i      (clk_i),
    .stage_en_i (stage_en[1 + LANE_STAGES +: CLIP_STAGES]),
    .curr_i     (curr),
    .y_o        (clip_y)
  );

  // both channels are summed into one clip result, so both outputs carry the same value
  assign out_valid_o = valid_q[NUM_STAGES-1];
  assign out_data_o  = '{out_left: clip_y, out_right: clip_y};

`ifndef SYNTHESIS
  // input held off only when every stage is occupied and the output stalls
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> ((&valid_q) && out_stall_i))
    else $error("input stalled with a free pipeline stage");

  // a new result comes only from the stage right before the output
  a_out_from_prev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(valid_q[NUM_STAGES-2]))
    else $error("result valid without an item in the previous stage");

  // the knee always sits at least the minimum gap above the bias
  a_knee_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (knee_q.gap >= REM_W'(KNEE_GAP_Q16)) && (knee_q.half_gap != '0))
    else $error("knee gap below minimum");
`endif

endmodule

// ===== hw/rtl/drm_diode_lane.sv =====
// ----------------------------------------------------------------------------
// drm_diode_lane
// One diode pair: magnitude, region select, square and a one-bit-per-stage
// restoring divider for the quadratic segment.
// ----------------------------------------------------------------------------
module drm_diode_lane import drm_pkg::*; (
  input  logic                      clk_i,
  input  logic [LANE_STAGES-1:0]    stage_en_i,
  input  drm_knee_t                 knee_i,
  input  logic signed [DIODE_W-1:0] volt_i,
  output logic [MAG_W-1:0]          curr_o
);

  typedef enum logic [1:0] {
    REGION_ZERO = 2'd0,
    REGION_QUAD = 2'd1,
    REGION_LIN  = 2'd2
  } region_e;

  logic signed [DIODE_W-1:0] neg_volt;
  logic [MAG_W-1:0]          mag_d, mag_q;

  logic [MAG_W-1:0] diff;
  region_e          region_d, region1_q;
  logic [D_W-1:0]   dlt_d, dlt_q;
  logic [MAG_W-1:0] lin_d, lin1_q;

  logic [2*D_W-1:0] sq;

  logic [REM_W-1:0] rem_q    [DIV_STAGES+1];
  logic [QUO_W-1:0] low_q    [DIV_STAGES+1];
  logic [QUO_W-1:0] quo_q    [DIV_STAGES+1];
  region_e          region_q [DIV_STAGES+1];
  logic [MAG_W-1:0] lin_q    [DIV_STAGES+1];

  logic [REM_W-1:0] rem_d [1:DIV_STAGES];
  logic [QUO_W-1:0] low_d [1:DIV_STAGES];
  logic [QUO_W-1:0] quo_d [1:DIV_STAGES];

  logic [MAG_W-1:0] curr_d, curr_q;

  // |v|: the diode pair +v / -v conducts on the magnitude only
  always_comb begin
    neg_volt = -volt_i;
    mag_d    = volt_i[DIODE_W-1] ? neg_volt[MAG_W-1:0] : volt_i[MAG_W-1:0];
  end

  // region and segment operands
  always_comb begin
    diff = mag_q - MAG_W'(knee_i.vb);
    if (mag_q < MAG_W'(knee_i.vb)) begin
      region_d = REGION_ZERO;
    end else if (mag_q < MAG_W'(knee_i.vl)) begin
      region_d = REGION_QUAD;
    end else begin
      region_d = REGION_LIN;
    end
    dlt_d = (region_d == REGION_QUAD) ? diff[D_W-1:0] : '0;
    lin_d = mag_q - MAG_W'(knee_i.vl) + MAG_W'(knee_i.half_gap);
  end

  assign sq = (2*D_W)'(dlt_q) * (2*D_W)'(dlt_q);

  // one quotient bit per stage, msb first
  always_comb begin
    logic [REM_W:0] trial;
    logic           take;
    for (int k = 1; k <= DIV_STAGES; k++) begin
      trial    = {rem_q[k-1], low_q[k-1][QUO_W-1]};
      take     = (trial >= {1'b0, knee_i.gap});
      rem_d[k] = take ? REM_W'(trial - {1'b0, knee_i.gap}) : trial[REM_W-1:0];
      low_d[k] = low_q[k-1] << 1;
      quo_d[k] = {quo_q[k-1][QUO_W-2:0], take};
    end
  end

  always_comb begin
    case (region_q[DIV_STAGES])
      REGION_ZERO: curr_d = '0;
      REGION_QUAD: curr_d = MAG_W'(quo_q[DIV_STAGES]);
      REGION_LIN:  curr_d = lin_q[DIV_STAGES];
      default:     curr_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[0]) begin
      mag_q <= mag_d;
    end
    if (stage_en_i[1]) begin
      region1_q <= region_d;
      dlt_q     <= dlt_d;
      lin1_q    <= lin_d;
    end
    if (stage_en_i[2]) begin
      rem_q[0]    <= sq[2*D_W-1 -: REM_W];
      low_q[0]    <= sq[SQ_SHIFT +: QUO_W];
      quo_q[0]    <= '0;
      region_q[0] <= region1_q;
      lin_q[0]    <= lin1_q;
    end
    for (int k = 1; k <= DIV_STAGES; k++) begin
      if (stage_en_i[k+2]) begin
        rem_q[k]    <= rem_d[k];
        low_q[k]    <= low_d[k];
        quo_q[k]    <= quo_d[k];
        region_q[k] <= region_q[k-1];
        lin_q[k]    <= lin_q[k-1];
      end
    end
    if (stage_en_i[DIV_STAGES+3]) begin
      curr_q <= curr_d;
    end
  end

  assign curr_o = curr_q;

endmodule

// ===== hw/rtl/drm_soft_clip.sv =====
// ----------------------------------------------------------------------------
// drm_soft_clip
// Channel sum of the diode currents, cubic soft clip 1.5x - 0.5x^3,
// rescale and saturation to the sample format.
// ----------------------------------------------------------------------------
module drm_soft_clip import drm_pkg::*; (
  input  logic                          clk_i,
  input  logic [CLIP_STAGES-1:0]        stage_en_i,
  input  logic [MAG_W-1:0]              curr_i [NUM_LANES],
  output logic signed [SAMPLE_BITS-1:0] y_o
);

  localparam int HI_BITS = Y_W - SAMPLE_BITS + 1;

  logic signed [X_W-1:0] x_d, x0_q, x1_q, x2_q, x3_q;
  logic signed [X_W-1:0] neg_x;
  logic [AX_W-1:0]       ax_d, ax1_q, ax2_q;
  logic                  neg1_q, neg2_q, neg3_q;
  logic [2*AX_W-1:0]     ax_sq;
  logic [S_W-1:0]        s2_q;
  logic [S_W+AX_W-1:0]   s_ax;
  logic [C_W-1:0]        cube3_q;

  logic signed [Z_W-1:0] xz, three_x, cube_s, z_d, z4_q;
  logic signed [Y_W-1:0] z_wide, yw;
  logic [HI_BITS-1:0]    upper;
  logic signed [SAMPLE_BITS-1:0] y_d, y_q;

  // currents are non-negative, the difference wraps into two's complement
  assign x_d = X_W'(curr_i[LANE_A_LEFT]) - X_W'(curr_i[LANE_B_LEFT])
             + X_W'(curr_i[LANE_A_RIGHT]) - X_W'(curr_i[LANE_B_RIGHT]);

  always_comb begin
    neg_x = -x0_q;
    ax_d  = x0_q[X_W-1] ? neg_x[AX_W-1:0] : x0_q[AX_W-1:0];
  end

  assign ax_sq = (2*AX_W)'(ax1_q) * (2*AX_W)'(ax1_q);
  assign s_ax  = (S_W+AX_W)'(s2_q) * (S_W+AX_W)'(ax2_q);

  // 3x - sign(x)*cube on the 2^-25 grid
  always_comb begin
    xz      = Z_W'(x3_q);
    three_x = xz + (xz <<< 1);
    cube_s  = $signed(Z_W'(cube3_q));
    z_d     = neg3_q ? three_x + cube_s : three_x - cube_s;
  end

  always_comb begin
    z_wide = Y_W'(z4_q);
    yw     = (z_wide <<< OUT_LSH) >>> OUT_RSH;
    upper  = yw[Y_W-1:SAMPLE_BITS-1];
    if ((&upper) || !(|upper)) begin
      y_d = yw[SAMPLE_BITS-1:0];
    end else if (yw[Y_W-1]) begin
      y_d = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      y_d = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[0]) begin
      x0_q <= x_d;
    end
    if (stage_en_i[1]) begin
      x1_q   <= x0_q;
      ax1_q  <= ax_d;
      neg1_q <= x0_q[X_W-1];
    end
    if (stage_en_i[2]) begin
      x2_q   <= x1_q;
      ax2_q  <= ax1_q;
      neg2_q <= neg1_q;
      s2_q   <= ax_sq[2*AX_W-1:DIODE_FRAC];
    end
    if (stage_en_i[3]) begin
      x3_q    <= x2_q;
      neg3_q  <= neg2_q;
      cube3_q <= s_ax[S_W+AX_W-1:DIODE_FRAC];
    end
    if (stage_en_i[4]) begin
      z4_q <= z_d;
    end
    if (stage_en_i[5]) begin
      y_q <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the diode ring modulator. A queue-fed driver
// offers stereo audio/carrier items with random gaps, a monitor checks
// every result against an in-bench fixed-point model of the diode ring and
// soft clip, and the output side stalls at random, once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
  import drm_pkg::*;

  // run limits
  localparam int WATCHDOG_CYCLES = 500000;
  localparam int DRAIN_CYCLES    = 40;    // pipeline is 34 deep
  localparam int SQUEEZE_AT      = 60;    // results seen before the long hold
  localparam int SQUEEZE_CYCLES  = 400;

  // sample extremes
  localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic clk_i;
  logic rst_ni = 1'b0;

  // block inputs, all known from time zero
  logic                 cfg_we    = 1'b0;
  cfg_idx_e             cfg_idx   = CFG_FORWARD_BIAS;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  drm_in_t              in_data   = '0;
  logic                 out_stall = 1'b0;

  // block outputs
  logic     in_stall;
  logic     out_valid;
  drm_out_t out_data;

  // bench copy of the two registers
  logic [CFG_W-1:0] bias_reg = FORWARD_BIAS_RESET;
  logic [CFG_W-1:0] knee_reg = LINEAR_KNEE_RESET;

  // items waiting to be offered, and predicted outputs waiting to arrive
  drm_in_t  sample_q[$];
  drm_out_t ring_out_q[$];

  // traffic shaping, changed only while the block is idle
  bit feed_gaps    = 1'b1;
  bit drain_stalls = 1'b1;

  int       gap_left;
  int       stall_left;
  int       squeeze_left;
  bit       squeeze_done;
  int       results_seen;
  int       errors = 0;
  int       cycles = 0;
  drm_out_t want;

  diode_ring_modulator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // --------------------------------------------------------------------------
  // fixed-point model of the ring
  // --------------------------------------------------------------------------

  // sample grid to the 2^-24 diode grid, floor when narrowing
  function automatic longint to_diode_grid(longint v);
    int sh;
    sh = DIODE_FRAC - SAMPLE_BITS;
    if (sh >= 0) return v <<< sh;
    return v >>> (-sh);
  endfunction

  // zero below bias, quadratic up to the knee, linear above
  function automatic longint diode_curve(longint v, longint vb, longint vl);
    longint g;
    g = vl - vb;
    if (v < vb) return 0;
    if (v < vl) return ((v - vb) * (v - vb)) / (2 * g);
    return v - vl + g / 2;
  endfunction

  // one channel: four diodes on A = in/2 + 2c and B = 2c - in/2
  function automatic longint ring_channel(longint audio, longint car, longint vb,
                                          longint vl);
    longint a, b;
    a = to_diode_grid(audio + 4 * car);
    b = to_diode_grid(4 * car - audio);
    return diode_curve(a, vb, vl) + diode_curve(-a, vb, vl)
         - diode_curve(b, vb, vl) - diode_curve(-b, vb, vl);
  endfunction

  function automatic drm_out_t ring_mod_predict(drm_in_t s, logic [CFG_W-1:0] bias,
                                                logic [CFG_W-1:0] knee);
    longint          vb, vl, x, c, z, y, hi, lo;
    longint unsigned ax, sq, cube;
    int              sh;
    drm_out_t        r;
    vb = longint'(bias);
    vl = longint'(knee);
    // knee never closer than the minimum gap above the bias
    if (vl < vb + KNEE_GAP_Q16) vl = vb + KNEE_GAP_Q16;
    vb = vb <<< BIAS_SHIFT;
    vl = vl <<< BIAS_SHIFT;
    x = ring_channel(longint'(s.left_in), longint'(s.carrier_left), vb, vl)
      + ring_channel(longint'(s.right_in), longint'(s.carrier_right), vb, vl);
    // cubic soft clip, 3x - x^3 on a 2^-25 grid
    ax   = (x < 0) ? -x : x;
    sq   = (ax * ax) >> DIODE_FRAC;
    cube = (sq * ax) >> DIODE_FRAC;
    c    = (x < 0) ? -$signed(cube) : $signed(cube);
    z    = 3 * x - c;
    sh   = SAMPLE_BITS - 1 - (DIODE_FRAC + 1);
    y    = (sh >= 0) ? (z <<< sh) : (z >>> (-sh));
    hi   = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
    lo   = -hi - 1;
    if (y > hi) y = hi;
    if (y < lo) y = lo;
    r.out_left  = y[SAMPLE_BITS-1:0];
    r.out_right = y[SAMPLE_BITS-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // random helpers
  // --------------------------------------------------------------------------

  // mostly no idle, some short, a few long
  function automatic int idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // full-range, extreme, or small values that sit around the diode bends
  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    int unsigned            pick;
    int unsigned            mag;
    logic [SAMPLE_BITS-1:0] v;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      case ($urandom_range(0, 3))
        0: v = S_MAX;
        1: v = S_MIN;
        2: v = '0;
        default: v = '1;
      endcase
    end else if (pick < 5) begin
      v = SAMPLE_BITS'($urandom);
    end else begin
      mag = $urandom_range(14, 22);
      v = SAMPLE_BITS'($urandom_range(0, (32'd1 << mag) - 1));
      if ($urandom_range(0, 1) == 1) v = -v;
    end
    return v;
  endfunction

  function automatic drm_in_t make_item(logic [SAMPLE_BITS-1:0] l, logic [SAMPLE_BITS-1:0] r,
                                        logic [SAMPLE_BITS-1:0] cl,
                                        logic [SAMPLE_BITS-1:0] cr);
    drm_in_t s;
    s.left_in       = l;
    s.right_in      = r;
    s.carrier_left  = cl;
    s.carrier_right = cr;
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // clock and watchdog
  // --------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > WATCHDOG_CYCLES) begin
      $display("%0t: watchdog expired, %0d results still due", $time, ring_out_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // driver: offers queued items, holds a stalled item steady
  // --------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      gap_left <= 0;
    end else begin
      // item taken: predict its output with the registers as they stand
      if (in_valid && !in_stall)
        ring_out_q.push_back(ring_mod_predict(in_data, bias_reg, knee_reg));
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (sample_q.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= sample_q.pop_front();
          gap_left <= feed_gaps ? idle_len() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // receiver stall: random holds plus one long squeeze to back up the pipe
  // --------------------------------------------------------------------------

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall    <= 1'b0;
      stall_left   <= 0;
      squeeze_left <= 0;
      squeeze_done <= 1'b0;
    end else if (!squeeze_done && results_seen >= SQUEEZE_AT) begin
      out_stall    <= 1'b1;
      squeeze_left <= SQUEEZE_CYCLES;
      squeeze_done <= 1'b1;
    end else if (squeeze_left > 0) begin
      out_stall    <= 1'b1;
      squeeze_left <= squeeze_left - 1;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (drain_stalls && $urandom_range(0, 99) < 25) begin
      out_stall  <= 1'b1;
      stall_left <= idle_len();
    end else begin
      out_stall <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // monitor: each taken result against the oldest prediction
  // --------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (ring_out_q.size() == 0) begin
        $display("%0t: result with no item pending: expected none, actual %0d / %0d",
                 $time, out_data.out_left, out_data.out_right);
        errors++;
      end else begin
        want = ring_out_q.pop_front();
        if (out_data.out_left !== want.out_left) begin
          $display("%0t: out_left mismatch: expected %0d, actual %0d",
                   $time, want.out_left, out_data.out_left);
          errors++;
        end
        if (out_data.out_right !== want.out_right) begin
          $display("%0t: out_right mismatch: expected %0d, actual %0d",
                   $time, want.out_right, out_data.out_right);
          errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus sequence
  // --------------------------------------------------------------------------

  // register write while the pipe is empty
  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_FORWARD_BIAS) bias_reg = val;
    else knee_reg = val;
  endtask

  // nothing queued, nothing offered, nothing outstanding
  task automatic wait_idle();
    while (sample_q.size() != 0 || in_valid || ring_out_q.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic run_random(int n);
    @(negedge clk_i);
    for (int i = 0; i < n; i++)
      sample_q.push_back(make_item(rand_sample(), rand_sample(), rand_sample(),
                                   rand_sample()));
    wait_idle();
  endtask

  task automatic set_config(logic [CFG_W-1:0] bias, logic [CFG_W-1:0] knee);
    write_reg(CFG_FORWARD_BIAS, bias);
    write_reg(CFG_LINEAR_KNEE, knee);
    @(negedge clk_i);
  endtask

  initial begin
    logic [CFG_W-1:0] rb;
    logic [CFG_W-1:0] rk;

    // reset held low from time zero, released away from the active edge
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed items on the reset registers
    // carriers at bias/4 and knee/4 put A exactly on the diode bends
    sample_q.push_back(make_item('0, '0, '0, '0));
    sample_q.push_back(make_item(S_MAX, S_MAX, S_MAX, S_MAX));
    sample_q.push_back(make_item(S_MIN, S_MIN, S_MIN, S_MIN));
    sample_q.push_back(make_item(S_MAX, '0, '0, '0));
    sample_q.push_back(make_item(S_MIN, '0, '0, '0));
    sample_q.push_back(make_item('0, '0, S_MAX, '0));
    sample_q.push_back(make_item('0, '0, S_MIN, '0));
    sample_q.push_back(make_item('0, S_MAX, '0, S_MAX));
    sample_q.push_back(make_item(S_MAX, S_MIN, S_MAX, S_MIN));
    sample_q.push_back(make_item(S_MIN, S_MAX, S_MAX, S_MIN));
    sample_q.push_back(make_item(S_MAX, S_MAX, S_MIN, S_MIN));
    sample_q.push_back(make_item(24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555));
    sample_q.push_back(make_item(24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA));
    sample_q.push_back(make_item('1, '1, '1, '1));
    sample_q.push_back(make_item('0, '0, 24'd1258304, '0));
    sample_q.push_back(make_item('0, '0, 24'd1258303, 24'd1258304));
    sample_q.push_back(make_item('0, '0, 24'd2936000, '0));
    sample_q.push_back(make_item('0, '0, 24'd2935999, -24'sd2936000));
    sample_q.push_back(make_item(24'd1, '0, 24'd2936000, '0));
    sample_q.push_back(make_item(S_MAX, S_MAX, '0, '0));
    sample_q.push_back(make_item(S_MIN, S_MAX, S_MAX, S_MAX));
    sample_q.push_back(make_item(S_MAX, S_MIN, S_MIN, S_MIN));
    sample_q.push_back(make_item(24'd4000000, 24'd4000000, 24'd2000000, 24'd2000000));
    wait_idle();

    // back-to-back offers; the long receiver hold lands in this phase
    feed_gaps = 1'b0;
    run_random(160);

    // knee equal to a zero bias: forced to the minimum gap above it
    feed_gaps    = 1'b0;
    drain_stalls = 1'b0;
    set_config('0, '0);
    run_random(70);

    // both at full scale, knee lifted past the top of its range
    feed_gaps    = 1'b1;
    drain_stalls = 1'b1;
    set_config('1, '1);
    run_random(70);

    // top bias, zero knee
    drain_stalls = 1'b0;
    set_config('1, '0);
    run_random(60);

    // zero bias, widest quadratic region
    feed_gaps    = 1'b0;
    drain_stalls = 1'b1;
    set_config('0, '1);
    run_random(60);

    // random settings, half of them with the knee near or under the bias
    feed_gaps = 1'b1;
    for (int p = 0; p < 3; p++) begin
      rb = CFG_W'($urandom);
      rk = ($urandom_range(0, 1) == 1) ? CFG_W'($urandom)
                                       : CFG_W'(rb + CFG_W'($urandom_range(0, 3000)));
      set_config(rb, rk);
      run_random(65);
    end

    // reset values written back explicitly
    set_config(FORWARD_BIAS_RESET, LINEAR_KNEE_RESET);
    run_random(60);

    // let any stray result show up before judging
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    if (ring_out_q.size() != 0) begin
      $display("%0t: %0d predicted results never arrived", $time, ring_out_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== diode_ring_modulator.f =====
hw/rtl/drm_pkg.sv
hw/rtl/drm_diode_lane.sv
hw/rtl/drm_soft_clip.sv
hw/rtl/diode_ring_modulator.sv
bench/tb.sv
